/* rtl/core/srsw_pkg.sv */
package srsw_pkg;

	localparam int OP_W   = 2;
	localparam int PKT_W  = 16;
	localparam int KIND_W = 3;

	localparam logic [OP_W-1:0] OP_START   = 2'd0;
	localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
	localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

	localparam logic [KIND_W-1:0] K_SEND     = 3'd0;
	localparam logic [KIND_W-1:0] K_INORDER  = 3'd1;
	localparam logic [KIND_W-1:0] K_OUTORDER = 3'd2;
	localparam logic [KIND_W-1:0] K_REJECT   = 3'd3;
	localparam logic [KIND_W-1:0] K_DONE     = 3'd4;

	typedef struct packed {
		logic              load;
		logic              apply_ack;
		logic              open;
		logic              open_zero;
		logic              step;
		logic              emit;
		logic [KIND_W-1:0] emit_kind;
		logic              emit_last;
		logic              set_active;
		logic              clr_active;
	} srsw_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic              active;
		logic [KIND_W-1:0] ack_kind;
		logic              ack_complete;
		logic              base_done;
		logic              send_last;
		logic              out_free;
	} srsw_sts_t;

endpackage

/* rtl/core/srsw_if.sv */
interface srsw_req_if import srsw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [PKT_W-1:0] ack_number;

	modport source (output valid, output opcode, output ack_number, input ready);
	modport sink (input valid, input opcode, input ack_number, output ready);
endinterface

interface srsw_rsp_if import srsw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [PKT_W-1:0]  packet_number;
	logic              last_of_run;

	modport source (output valid, output kind, output packet_number, output last_of_run,
		input ready);
	modport sink (input valid, input kind, input packet_number, input last_of_run,
		output ready);
endinterface

/* rtl/core/selective_repeat_sender_window_unit.sv */
// Sender-side window control for a selective-repeat transfer.
// Channels: req (opcode, ack_number) carries start, acknowledgement and
// timeout requests; rsp (kind, packet_number, last_of_run) carries the
// results, one per cycle while the receiver keeps up, with last_of_run on the final result of a request.
// cfg_we/cfg_wdata write the packet total; write it only while idle.
// Sequence: a request is taken in ST_IDLE and evaluated in the next cycle, in
// ST_EVAL. An acknowledgement gives its classification there once the result
// register is free; when it completes the window, ST_OPEN opens the next one,
// then ST_EMIT issues one send command per cycle while the result register is
// free. The controller takes one request at a time and the window is walked
// by one send counter.
// The result register lets the next request be taken while the last result
// waits. When the receiver stalls, the controller holds until the result
// register drains and no result is lost.
// Reset clears the window, the packet total and the transfer state; reset sets
// req.ready, so the block is ready for a request once reset is released.
module selective_repeat_sender_window_unit import srsw_pkg::*; #(
	parameter int WINDOW = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [PKT_W-1:0] cfg_wdata,
	srsw_req_if.sink         req,
	srsw_rsp_if.source       rsp
);

	srsw_cmd_t cmd;
	srsw_sts_t sts;
	logic      ready;

	srsw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	srsw_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.req_opcode        (req.opcode),
		.req_ack_number    (req.ack_number),
		.cmd               (cmd),
		.sts               (sts),
		.rsp_ready         (rsp.ready),
		.rsp_valid         (rsp.valid),
		.rsp_kind          (rsp.kind),
		.rsp_packet_number (rsp.packet_number),
		.rsp_last_of_run   (rsp.last_of_run)
	);

	assign req.ready = ready;

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a previous one is still in work");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result written over one not yet taken");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.emit_kind == K_DONE |=> !sts.active)
		else $error("transfer still active after completion");

endmodule

/* rtl/core/srsw_dp.sv */
module srsw_dp import srsw_pkg::*; #(
	parameter int WINDOW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [PKT_W-1:0]  cfg_wdata,
	input  logic [OP_W-1:0]   req_opcode,
	input  logic [PKT_W-1:0]  req_ack_number,
	input  srsw_cmd_t         cmd,
	output srsw_sts_t         sts,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output logic [KIND_W-1:0] rsp_kind,
	output logic [PKT_W-1:0]  rsp_packet_number,
	output logic              rsp_last_of_run
);

	localparam int IDXW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW   = $clog2(WINDOW + 1);
	localparam int EW   = PKT_W + 1;

	logic [PKT_W-1:0]  total_q;
	logic [PKT_W-1:0]  base_q;
	logic [PKT_W-1:0]  exp_q;
	logic [WINDOW-1:0] map_q;
	logic [CW-1:0]     cnt_q;
	logic              active_q;
	logic [OP_W-1:0]   op_q;
	logic [PKT_W-1:0]  ack_q;
	logic [PKT_W-1:0]  pkt_q;
	logic              valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [PKT_W-1:0]  out_pkt_q;
	logic              last_q;

	logic [EW-1:0]     base_x;
	logic [EW-1:0]     exp_x;
	logic [EW-1:0]     ack_x;
	logic [EW-1:0]     sum_x;
	logic [EW-1:0]     total_x;
	logic [EW-1:0]     end_x;
	logic [EW-1:0]     span_x;
	logic [EW-1:0]     cand_x;
	logic              in_order;
	logic              out_order;
	logic [IDXW-1:0]   idx;
	logic [WINDOW-1:0] bit_sel;
	logic              dup;
	logic              marked;
	logic [WINDOW-1:0] map_new;
	logic [CW-1:0]     cnt_new;
	logic [CW-1:0]     ffz;
	logic [PKT_W-1:0]  exp_nxt;
	logic [PKT_W-1:0]  open_val;
	logic [PKT_W-1:0]  emit_pkt;

	assign base_x  = {1'b0, base_q};
	assign exp_x   = {1'b0, exp_q};
	assign ack_x   = {1'b0, ack_q};
	assign total_x = {1'b0, total_q};
	assign sum_x   = base_x + EW'(WINDOW);
	assign end_x   = (sum_x < total_x) ? sum_x : total_x;
	assign span_x  = end_x - base_x;

	assign in_order  = active_q && (ack_q == exp_q) && (exp_x < end_x);
	assign out_order = active_q && !in_order && (ack_x > exp_x) && (ack_x < end_x);
	assign idx       = IDXW'(ack_q - base_q);
	assign bit_sel   = WINDOW'(1) << idx;
	assign dup       = (map_q & bit_sel) != '0;
	assign marked    = in_order || (out_order && !dup);
	assign map_new   = marked ? (map_q | bit_sel) : map_q;
	assign cnt_new   = cnt_q + CW'(marked);

	always_comb begin
		ffz = CW'(WINDOW);
		for (int i = WINDOW - 1; i >= 0; i--) begin
			if (!map_new[i]) begin
				ffz = CW'(i);
			end
		end
	end

	assign cand_x  = base_x + EW'(ffz);
	assign exp_nxt = (cand_x < end_x) ? cand_x[PKT_W-1:0] : end_x[PKT_W-1:0];

	assign open_val = cmd.open_zero ? '0 : exp_q;

	always_comb begin
		priority if (cmd.emit_kind == K_SEND) begin
			emit_pkt = pkt_q;
		end else if (cmd.emit_kind == K_DONE) begin
			emit_pkt = '0;
		end else begin
			emit_pkt = ack_q;
		end
	end

	always_comb begin
		sts.opcode       = op_q;
		sts.active       = active_q;
		sts.ack_kind     = in_order ? K_INORDER : (out_order ? K_OUTORDER : K_REJECT);
		sts.ack_complete = marked && (end_x > base_x) && ({{(EW-CW){1'b0}}, cnt_new} >= span_x);
		sts.base_done    = base_q >= total_q;
		sts.send_last    = ({1'b0, pkt_q} + EW'(1)) >= end_x;
		sts.out_free     = !valid_q || rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			base_q   <= '0;
			exp_q    <= '0;
			map_q    <= '0;
			cnt_q    <= '0;
			active_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (cmd.set_active) begin
				active_q <= 1'b1;
			end else if (cmd.clr_active) begin
				active_q <= 1'b0;
			end
			if (cmd.apply_ack) begin
				map_q <= map_new;
				cnt_q <= cnt_new;
				if (in_order) begin
					exp_q <= exp_nxt;
				end
			end else if (cmd.open) begin
				base_q <= open_val;
				exp_q  <= open_val;
				map_q  <= '0;
				cnt_q  <= '0;
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (rsp_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_opcode;
			ack_q <= req_ack_number;
		end
		if (cmd.open) begin
			pkt_q <= open_val;
		end else if (cmd.step) begin
			pkt_q <= pkt_q + PKT_W'(1);
		end
		if (cmd.emit) begin
			kind_q    <= cmd.emit_kind;
			out_pkt_q <= emit_pkt;
			last_q    <= cmd.emit_last;
		end
	end

	assign rsp_valid         = valid_q;
	assign rsp_kind          = kind_q;
	assign rsp_packet_number = out_pkt_q;
	assign rsp_last_of_run   = last_q;

endmodule

/* rtl/core/srsw_ctrl.sv */
module srsw_ctrl import srsw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  srsw_sts_t sts,
	output srsw_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_OPEN,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rdy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = req_valid;
				if (req_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				unique case (sts.opcode)
					OP_START: begin
						cmd.set_active = 1'b1;
						cmd.open       = 1'b1;
						cmd.open_zero  = 1'b1;
						state_d        = ST_EMIT;
					end
					OP_ACK: begin
						if (sts.out_free) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = sts.ack_kind;
							cmd.emit_last = !sts.ack_complete;
							cmd.apply_ack = 1'b1;
							state_d       = sts.ack_complete ? ST_OPEN : ST_IDLE;
						end
					end
					OP_TIMEOUT: begin
						if (sts.active) begin
							cmd.open = 1'b1;
							state_d  = ST_EMIT;
						end else begin
							state_d = ST_IDLE;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_OPEN: begin
				cmd.open = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.base_done) begin
						cmd.emit_kind  = K_DONE;
						cmd.emit_last  = 1'b1;
						cmd.clr_active = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						cmd.emit_kind = K_SEND;
						cmd.emit_last = sts.send_last;
						cmd.step      = 1'b1;
						if (sts.send_last) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			rdy_q   <= state_d == ST_IDLE;
		end
	end

	assign req_ready = rdy_q;

endmodule
